>>> hw/rtl/gtl_pkg.sv
`timescale 1ns / 1ps

package gtl_pkg;

  // Glyph table geometry
  localparam int unsigned MAX_GLYPHS     = 256;
  localparam int unsigned TEX_COORD_BITS = 12;
  localparam int unsigned GLYPH_AW       = $clog2(MAX_GLYPHS);
  localparam int unsigned CNT_W          = GLYPH_AW + 1;
  localparam int unsigned RECT_W         = 4 * TEX_COORD_BITS;
  localparam int unsigned METRIC_W       = 36;
  localparam int unsigned ACC_W          = 24;

  // Function selector codes
  localparam logic [1:0] FUNC_LOAD   = 2'd0;
  localparam logic [1:0] FUNC_LAYOUT = 2'd1;
  localparam logic [1:0] FUNC_NEW    = 2'd2;
  localparam logic [1:0] FUNC_NONE   = 2'd3;

  // Configuration register indexes
  localparam logic [2:0] REG_GLYPH_COUNT  = 3'd0;
  localparam logic [2:0] REG_LINE_SPACING = 3'd1;
  localparam logic [2:0] REG_DEFAULT_CHAR = 3'd2;
  localparam logic [2:0] REG_ORIGIN_X     = 3'd3;
  localparam logic [2:0] REG_ORIGIN_Y     = 3'd4;

  // Character codes with special handling
  localparam logic [15:0] CHAR_TAB   = 16'h0009;
  localparam logic [15:0] CHAR_LF    = 16'h000A;
  localparam logic [15:0] CHAR_CR    = 16'h000D;
  localparam logic [15:0] CHAR_SPACE = 16'h0020;

  typedef enum logic [1:0] {
    ST_ACK     = 2'd0,
    ST_PLACED  = 2'd1,
    ST_SKIPPED = 2'd2,
    ST_MISSING = 2'd3
  } status_e;

  typedef enum logic [4:0] {
    S_IDLE,
    S_LF,
    S_SRCH_CH,
    S_SRCH_DEF,
    S_FETCH,
    S_W,
    S_H,
    S_PX,
    S_DL0,
    S_DL1,
    S_DT0,
    S_DT1,
    S_DR,
    S_DB,
    S_LEN0,
    S_LEN1,
    S_ADV0,
    S_ADV1
  } lay_state_e;

  typedef enum logic [1:0] {
    SR_IDLE,
    SR_CHK,
    SR_CMP,
    SR_FIN
  } srch_state_e;

  typedef struct packed {
    logic [1:0]         func;
    logic [7:0]         glyph_index;
    logic [15:0]        glyph_code;
    logic [11:0]        src_left;
    logic [11:0]        src_top;
    logic [11:0]        src_right;
    logic [11:0]        src_bottom;
    logic signed [11:0] x_offset;
    logic signed [11:0] y_offset;
    logic signed [11:0] x_advance;
    logic [15:0]        character;
  } in_t;

  typedef struct packed {
    status_e            status;
    logic [11:0]        out_src_left;
    logic [11:0]        out_src_top;
    logic [11:0]        out_src_right;
    logic [11:0]        out_src_bottom;
    logic signed [15:0] dest_left;
    logic signed [15:0] dest_top;
    logic signed [15:0] dest_right;
    logic signed [15:0] dest_bottom;
    logic signed [23:0] string_length;
  } out_t;

  // Search request, response and code table write port
  typedef struct packed {
    logic             start;
    logic [15:0]      key;
    logic [CNT_W-1:0] count;
  } srch_req_t;

  typedef struct packed {
    logic                done;
    logic                found;
    logic [GLYPH_AW-1:0] slot;
  } srch_rsp_t;

  typedef struct packed {
    logic                en;
    logic [GLYPH_AW-1:0] addr;
    logic [15:0]         code;
  } code_wr_t;

endpackage

>>> hw/rtl/gtl_search.sv
`timescale 1ns / 1ps

// Lower-bound binary search over the sorted code table; each probe is a check state and a compare state.
module gtl_search (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  gtl_pkg::code_wr_t     wr_i,
  input  gtl_pkg::srch_req_t    req_i,
  output gtl_pkg::srch_rsp_t    rsp_o
);

  logic [15:0] code_mem [gtl_pkg::MAX_GLYPHS];
  logic [15:0] rd_q;

  gtl_pkg::srch_state_e state_q, state_d;
  logic [gtl_pkg::CNT_W-1:0] lo_q, lo_d, hi_q, hi_d, n_q, n_d, mid_q, mid_d;
  logic [15:0] key_q, key_d;
  logic [gtl_pkg::CNT_W:0] mid_sum;
  logic [gtl_pkg::CNT_W-1:0] mid;
  logic [gtl_pkg::CNT_W-1:0] rd_idx;
  logic                      in_range;

  assign mid_sum  = {1'b0, lo_q} + {1'b0, hi_q};
  assign mid      = mid_sum[gtl_pkg::CNT_W:1];
  assign in_range = lo_q < hi_q;
  assign rd_idx   = in_range ? mid : lo_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      code_mem[wr_i.addr] <= wr_i.code;
    end
    rd_q <= code_mem[rd_idx[gtl_pkg::GLYPH_AW-1:0]];
  end

  always_comb begin
    state_d     = state_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    n_d         = n_q;
    mid_d       = mid_q;
    key_d       = key_q;
    rsp_o.done  = 1'b0;
    rsp_o.found = 1'b0;
    rsp_o.slot  = lo_q[gtl_pkg::GLYPH_AW-1:0];
    unique case (state_q)
      gtl_pkg::SR_IDLE: begin
        // Hold until a request arrives
      end
      gtl_pkg::SR_CHK: begin
        if (in_range) begin
          mid_d   = mid;
          state_d = gtl_pkg::SR_CMP;
        end else if (lo_q < n_q) begin
          state_d = gtl_pkg::SR_FIN;
        end else begin
          rsp_o.done = 1'b1;
          state_d    = gtl_pkg::SR_IDLE;
        end
      end
      gtl_pkg::SR_CMP: begin
        if (rd_q < key_q) begin
          lo_d = mid_q + gtl_pkg::CNT_W'(1);
        end else begin
          hi_d = mid_q;
        end
        state_d = gtl_pkg::SR_CHK;
      end
      gtl_pkg::SR_FIN: begin
        rsp_o.done  = 1'b1;
        rsp_o.found = (rd_q == key_q);
        state_d     = gtl_pkg::SR_IDLE;
      end
    endcase
    // Take a new request in any state; one arriving mid-search restarts the search
    if (req_i.start) begin
      lo_d    = '0;
      hi_d    = req_i.count;
      n_d     = req_i.count;
      key_d   = req_i.key;
      state_d = gtl_pkg::SR_CHK;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= gtl_pkg::SR_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lo_q  <= lo_d;
    hi_q  <= hi_d;
    n_q   <= n_d;
    mid_q <= mid_d;
    key_q <= key_d;
  end

endmodule

>>> hw/rtl/glyph_text_layout.sv
`timescale 1ns / 1ps

// Glyph text layout. Load the glyph table entry by entry in ascending code order (func 0),
// open a string (func 2), then lay out characters (func 1). A command is taken when start
// is high and busy low; every command yields exactly one result on out_o, shown for a
// single cycle with out_valid_o, which the receiver must take then since it cannot stall.
// Load, new string, the unused selector and carriage return never raise busy: the result
// is shown in the cycle after acceptance. Newline holds busy through its line-feed state,
// which moves the pen to the next line and registers the result. A character costs one or
// two lower-bound searches (fallback to a nonzero default_character) through the single
// code-table read port, each probe a check and a compare state, then a final check and a
// finish state when the bound lies inside the table, at most ceil(log2(glyph_count+1))
// probes; then a fetch state and the steps on the one shared 24-bit adder that form width,
// height, pen bearing, destination corners, running length and advance (whitespace skips
// the rectangle and length steps). Results come from the registered output stage, so the
// next command can be issued in the cycle its predecessor's result is shown.
// Configuration writes are taken at any time but belong between commands. Tables are not
// cleared at reset.
module glyph_text_layout (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  gtl_pkg::in_t       in_i,
  output logic               out_valid_o,
  output gtl_pkg::out_t      out_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [2:0]         cfg_index_i,
  input  logic [15:0]        cfg_data_i
);

  localparam int unsigned TB = gtl_pkg::TEX_COORD_BITS;
  localparam int unsigned AW = gtl_pkg::ACC_W;

  // Configuration registers
  logic [8:0]  glyph_count_q;
  logic [11:0] line_spacing_q;
  logic [15:0] default_char_q;
  logic [15:0] origin_x_q;
  logic [15:0] origin_y_q;

  // Layout state and sequencer
  gtl_pkg::lay_state_e state_q, state_d;
  logic [15:0]   pen_x_q, pen_x_d, pen_y_q, pen_y_d;
  logic [AW-1:0] length_q, length_d;
  logic [AW-1:0] w_q, w_d, h_q, h_d;
  logic [15:0]   ch_q, ch_d;
  logic [gtl_pkg::GLYPH_AW-1:0] slot_q, slot_d;
  gtl_pkg::out_t res_q, res_d;
  logic          out_valid_q, out_valid_d;

  // Glyph attribute memories
  logic [gtl_pkg::RECT_W-1:0]   rect_mem   [gtl_pkg::MAX_GLYPHS];
  logic [gtl_pkg::METRIC_W-1:0] metric_mem [gtl_pkg::MAX_GLYPHS];
  logic [gtl_pkg::RECT_W-1:0]   rect_rd_q;
  logic [gtl_pkg::METRIC_W-1:0] metric_rd_q;

  // Shared adder
  logic [AW-1:0] add_a, add_b, add_y;
  logic          add_sub;

  logic accept, load_ok, white;
  logic [TB-1:0] sl, st, sr, sb;
  logic [AW-1:0] xo, yo, xa;
  logic [gtl_pkg::CNT_W-1:0] count_sat;

  gtl_pkg::srch_req_t srch_req;
  gtl_pkg::srch_rsp_t srch_rsp;
  gtl_pkg::code_wr_t  code_wr;

  assign accept      = start && !busy;
  assign busy        = (state_q != gtl_pkg::S_IDLE);
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_o       = res_q;

  assign load_ok = accept && (in_i.func == gtl_pkg::FUNC_LOAD)
                   && (32'(in_i.glyph_index) < gtl_pkg::MAX_GLYPHS);

  assign code_wr.en   = load_ok;
  assign code_wr.addr = gtl_pkg::GLYPH_AW'(in_i.glyph_index);
  assign code_wr.code = in_i.glyph_code;

  // Saturate the entry count at the table depth
  assign count_sat = (32'(glyph_count_q) > gtl_pkg::MAX_GLYPHS)
                     ? gtl_pkg::CNT_W'(gtl_pkg::MAX_GLYPHS)
                     : gtl_pkg::CNT_W'(glyph_count_q);

  gtl_search u_search (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .wr_i   (code_wr),
    .req_i  (srch_req),
    .rsp_o  (srch_rsp)
  );

  always_ff @(posedge clk_i) begin
    if (load_ok) begin
      rect_mem[code_wr.addr] <= {TB'(in_i.src_bottom), TB'(in_i.src_right),
                                 TB'(in_i.src_top), TB'(in_i.src_left)};
      metric_mem[code_wr.addr] <= {in_i.x_advance, in_i.y_offset, in_i.x_offset};
    end
    rect_rd_q   <= rect_mem[slot_q];
    metric_rd_q <= metric_mem[slot_q];
  end

  assign sl = rect_rd_q[TB-1:0];
  assign st = rect_rd_q[2*TB-1:TB];
  assign sr = rect_rd_q[3*TB-1:2*TB];
  assign sb = rect_rd_q[4*TB-1:3*TB];
  assign xo = AW'($signed(metric_rd_q[11:0]));
  assign yo = AW'($signed(metric_rd_q[23:12]));
  assign xa = AW'($signed(metric_rd_q[35:24]));

  // Tab to carriage return and space move the pen but draw nothing
  assign white = ((ch_q >= gtl_pkg::CHAR_TAB) && (ch_q <= gtl_pkg::CHAR_CR))
                 || (ch_q == gtl_pkg::CHAR_SPACE);

  assign add_y = add_a + (add_sub ? ~add_b : add_b) + AW'(add_sub);

  always_comb begin
    state_d        = state_q;
    pen_x_d        = pen_x_q;
    pen_y_d        = pen_y_q;
    length_d       = length_q;
    w_d            = w_q;
    h_d            = h_q;
    ch_d           = ch_q;
    slot_d         = slot_q;
    res_d          = res_q;
    out_valid_d    = 1'b0;
    add_a          = AW'(pen_x_q);
    add_b          = w_q;
    add_sub        = 1'b0;
    srch_req.start = 1'b0;
    srch_req.key   = (state_q == gtl_pkg::S_IDLE) ? in_i.character : default_char_q;
    srch_req.count = count_sat;

    unique case (state_q)
      gtl_pkg::S_IDLE: begin
        if (accept) begin
          res_d        = '0;
          res_d.status = gtl_pkg::ST_ACK;
          ch_d         = in_i.character;
          unique case (in_i.func)
            gtl_pkg::FUNC_LOAD: begin
              out_valid_d = 1'b1;
            end
            gtl_pkg::FUNC_NEW: begin
              pen_x_d     = '0;
              pen_y_d     = '0;
              length_d    = '0;
              out_valid_d = 1'b1;
            end
            gtl_pkg::FUNC_LAYOUT: begin
              if (in_i.character == gtl_pkg::CHAR_CR) begin
                res_d.status        = gtl_pkg::ST_SKIPPED;
                res_d.string_length = length_q;
                out_valid_d         = 1'b1;
              end else if (in_i.character == gtl_pkg::CHAR_LF) begin
                state_d = gtl_pkg::S_LF;
              end else begin
                srch_req.start = 1'b1;
                state_d        = gtl_pkg::S_SRCH_CH;
              end
            end
            gtl_pkg::FUNC_NONE: begin
              out_valid_d = 1'b1;
            end
          endcase
        end
      end
      gtl_pkg::S_LF: begin
        add_a               = AW'(pen_y_q);
        add_b               = AW'(line_spacing_q);
        pen_y_d             = add_y[15:0];
        pen_x_d             = '0;
        res_d.status        = gtl_pkg::ST_SKIPPED;
        res_d.string_length = length_q;
        out_valid_d         = 1'b1;
        state_d             = gtl_pkg::S_IDLE;
      end
      gtl_pkg::S_SRCH_CH, gtl_pkg::S_SRCH_DEF: begin
        if (srch_rsp.done) begin
          slot_d = srch_rsp.slot;
          if (srch_rsp.found) begin
            state_d = gtl_pkg::S_FETCH;
          end else if ((state_q == gtl_pkg::S_SRCH_CH) && (default_char_q != '0)) begin
            // Retry with the fallback character
            srch_req.start = 1'b1;
            state_d        = gtl_pkg::S_SRCH_DEF;
          end else begin
            res_d.status        = gtl_pkg::ST_MISSING;
            res_d.string_length = length_q;
            out_valid_d         = 1'b1;
            state_d             = gtl_pkg::S_IDLE;
          end
        end
      end
      gtl_pkg::S_FETCH: begin
        state_d = gtl_pkg::S_W;
      end
      gtl_pkg::S_W: begin
        add_a   = AW'(sr);
        add_b   = AW'(sl);
        add_sub = 1'b1;
        w_d     = add_y;
        state_d = gtl_pkg::S_H;
      end
      gtl_pkg::S_H: begin
        add_a   = AW'(sb);
        add_b   = AW'(st);
        add_sub = 1'b1;
        h_d     = add_y;
        state_d = gtl_pkg::S_PX;
      end
      gtl_pkg::S_PX: begin
        // Move by the bearing and clamp a negative pen at zero
        add_a   = AW'(pen_x_q);
        add_b   = xo;
        pen_x_d = add_y[15] ? '0 : add_y[15:0];
        state_d = white ? gtl_pkg::S_ADV0 : gtl_pkg::S_DL0;
      end
      gtl_pkg::S_DL0: begin
        add_a                = AW'(origin_x_q);
        add_b                = AW'(pen_x_q);
        res_d.dest_left      = add_y[15:0];
        res_d.out_src_left   = 12'(sl);
        res_d.out_src_top    = 12'(st);
        res_d.out_src_right  = 12'(sr);
        res_d.out_src_bottom = 12'(sb);
        state_d              = gtl_pkg::S_DL1;
      end
      gtl_pkg::S_DL1: begin
        // The bearing counts a second time on the destination left
        add_a           = AW'(res_q.dest_left);
        add_b           = xo;
        res_d.dest_left = add_y[15:0];
        state_d         = gtl_pkg::S_DT0;
      end
      gtl_pkg::S_DT0: begin
        add_a          = AW'(origin_y_q);
        add_b          = AW'(pen_y_q);
        res_d.dest_top = add_y[15:0];
        state_d        = gtl_pkg::S_DT1;
      end
      gtl_pkg::S_DT1: begin
        add_a          = AW'(res_q.dest_top);
        add_b          = yo;
        res_d.dest_top = add_y[15:0];
        state_d        = gtl_pkg::S_DR;
      end
      gtl_pkg::S_DR: begin
        add_a            = AW'(res_q.dest_left);
        add_b            = w_q;
        res_d.dest_right = add_y[15:0];
        state_d          = gtl_pkg::S_DB;
      end
      gtl_pkg::S_DB: begin
        add_a             = AW'(res_q.dest_top);
        add_b             = h_q;
        res_d.dest_bottom = add_y[15:0];
        state_d           = gtl_pkg::S_LEN0;
      end
      gtl_pkg::S_LEN0: begin
        add_a    = length_q;
        add_b    = w_q;
        length_d = add_y;
        state_d  = gtl_pkg::S_LEN1;
      end
      gtl_pkg::S_LEN1: begin
        add_a    = length_q;
        add_b    = xo;
        length_d = add_y;
        state_d  = gtl_pkg::S_ADV0;
      end
      gtl_pkg::S_ADV0: begin
        add_a   = AW'(pen_x_q);
        add_b   = w_q;
        pen_x_d = add_y[15:0];
        state_d = gtl_pkg::S_ADV1;
      end
      gtl_pkg::S_ADV1: begin
        add_a               = AW'(pen_x_q);
        add_b               = xa;
        pen_x_d             = add_y[15:0];
        res_d.status        = white ? gtl_pkg::ST_SKIPPED : gtl_pkg::ST_PLACED;
        res_d.string_length = length_q;
        out_valid_d         = 1'b1;
        state_d             = gtl_pkg::S_IDLE;
      end
      default: begin
        state_d = gtl_pkg::S_IDLE;
      end
    endcase
  end

  // Control state and configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= gtl_pkg::S_IDLE;
      out_valid_q    <= 1'b0;
      pen_x_q        <= '0;
      pen_y_q        <= '0;
      length_q       <= '0;
      glyph_count_q  <= '0;
      line_spacing_q <= '0;
      default_char_q <= '0;
      origin_x_q     <= '0;
      origin_y_q     <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      pen_x_q     <= pen_x_d;
      pen_y_q     <= pen_y_d;
      length_q    <= length_d;
      if (cfg_valid_i && cfg_ready_o) begin
        unique case (cfg_index_i)
          gtl_pkg::REG_GLYPH_COUNT:  glyph_count_q  <= cfg_data_i[8:0];
          gtl_pkg::REG_LINE_SPACING: line_spacing_q <= cfg_data_i[11:0];
          gtl_pkg::REG_DEFAULT_CHAR: default_char_q <= cfg_data_i;
          gtl_pkg::REG_ORIGIN_X:     origin_x_q     <= cfg_data_i;
          gtl_pkg::REG_ORIGIN_Y:     origin_y_q     <= cfg_data_i;
          default: begin
            // Drop writes beyond the register list
          end
        endcase
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    w_q    <= w_d;
    h_q    <= h_d;
    ch_q   <= ch_d;
    slot_q <= slot_d;
    res_q  <= res_d;
  end

  // A load is acknowledged in the very next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && in_i.func == gtl_pkg::FUNC_LOAD)
      |=> (out_valid_o && out_o.status == gtl_pkg::ST_ACK))
    else $error("load transaction not acknowledged");

  // Search completions only arrive while the sequencer waits for them
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    srch_rsp.done |-> (state_q == gtl_pkg::S_SRCH_CH || state_q == gtl_pkg::S_SRCH_DEF))
    else $error("unexpected search completion");

  // Results that place nothing carry no rectangle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_o.status != gtl_pkg::ST_PLACED)
      |-> (out_o.dest_left == '0 && out_o.out_src_right == '0))
    else $error("rectangle on a result that places nothing");

endmodule
